// ===== rtl/hst_pkg.sv =====
// Shared types and constants for the heat stencil sweep core.
// No dependencies; used by heat_stencil_inplace_sweep_core.
package hst_pkg;

   localparam int DATA_BITS   = 32;
   localparam int MAX_WIDTH   = 512;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = 12;
   localparam int WIDTH_BITS  = 10;
   localparam int HEIGHT_BITS = 13;
   localparam int GAIN_BITS   = 15;

   localparam logic [GAIN_BITS-1:0]   GAIN_MAX    = 15'd16384;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN   = 10'd3;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX   = 10'(MAX_WIDTH);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN  = 13'd3;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX  = 13'd4096;

   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 15'd14746;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 10'd500;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd500;

   // register indexes on the csr port
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_GAIN   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT = 2'd2;
   localparam int CSR_DATA_BITS = 16;

   // output queue
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);

   typedef struct packed {
      logic signed [DATA_BITS-1:0] temp;
      logic [ROW_BITS-1:0]         row;
      logic [COL_BITS-1:0]         col;
      logic                        last;
   } result_type;

   // per-cell control that rides along the pipeline
   typedef struct packed {
      logic                 do_upd;   // row > 0: finishes the cell above
      logic                 interior; // finished cell is not on the border
      logic                 emit_cur; // last row: report the cell itself too
      logic                 last;     // last column; final cell of the sweep in the last row
      logic [ROW_BITS-1:0]  row;
      logic [COL_BITS-1:0]  col;
   } cell_ctl_type;

endpackage

// ===== rtl/heat_stencil_inplace_sweep_core.sv =====
// Top level of the heat stencil sweep core: counters, row memories,
// stencil pipeline and output queue. Depends on hst_pkg.
//
// Streams one raster sweep of Q15.16 temperatures and reports the updated
// grid one row behind. Interior cells get old + k*(N + S + W + E - 4*old),
// where N and W are values already updated in this sweep (in-place order),
// rounded to Q.16 and saturated to 32 bits; border cells pass unchanged.
// Throughput is one cell per clock while the output queue has room for
// two results; in the last row each cell produces two results (the
// finished cell above and the cell itself) and the single result port
// then sets the pace. A request passes through the synchronous row memory
// read, the neighbor sum, the gain multiply and the west term, which
// closes the loop on the previous result (west neighbor = previous
// result). Geometry and gain may be written only while the core is idle.
// Out-of-range register values are clamped on write: width to 3..512,
// height to 3..4096, gain to 16384. A sweep restarts on sweep_start or
// after the final cell of the previous sweep.
module heat_stencil_inplace_sweep_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [hst_pkg::DATA_BITS-1:0]    req_temp_in,
   input  logic                                    req_sweep_start,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [hst_pkg::DATA_BITS-1:0]    rsp_temp_out,
   output logic [hst_pkg::ROW_BITS-1:0]            rsp_out_row,
   output logic [hst_pkg::COL_BITS-1:0]            rsp_out_col,
   output logic                                    rsp_sweep_last,
   // configuration
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [hst_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [hst_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int DB  = hst_pkg::DATA_BITS;
   localparam int CB  = hst_pkg::COL_BITS;
   localparam int RB  = hst_pkg::ROW_BITS;
   localparam int WB  = hst_pkg::WIDTH_BITS;
   localparam int HB  = hst_pkg::HEIGHT_BITS;
   localparam int GB  = hst_pkg::GAIN_BITS;
   localparam int PB  = DB + 3;          // N + S + E - 4*old
   localparam int MB  = PB + GB;         // part * k
   localparam int WKB = DB + GB;         // west * k
   localparam int SB  = MB + 1;          // rounded total
   localparam int NB  = PB + 1;          // old + delta before saturation
   localparam int QB  = hst_pkg::OUTQ_PTR_BITS;

   // ---------------------------------------------------------------
   // Configuration registers (stored already clamped)
   // ---------------------------------------------------------------
   logic [GB-1:0] gain_ff;
   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;
   logic [GB-1:0] gain_wr;
   logic [WB-1:0] width_wr;
   logic [HB-1:0] height_wr;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_wr   = csr_wdata[GB-1:0];
      width_wr  = csr_wdata[WB-1:0];
      height_wr = csr_wdata[HB-1:0];
      if (gain_wr > hst_pkg::GAIN_MAX) gain_wr = hst_pkg::GAIN_MAX;
      if (width_wr < hst_pkg::WIDTH_MIN) width_wr = hst_pkg::WIDTH_MIN;
      if (width_wr > hst_pkg::WIDTH_MAX) width_wr = hst_pkg::WIDTH_MAX;
      if (height_wr < hst_pkg::HEIGHT_MIN) height_wr = hst_pkg::HEIGHT_MIN;
      if (height_wr > hst_pkg::HEIGHT_MAX) height_wr = hst_pkg::HEIGHT_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= hst_pkg::GAIN_RESET;
         width_ff  <= hst_pkg::WIDTH_RESET;
         height_ff <= hst_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hst_pkg::CSR_STEP_GAIN:   gain_ff   <= gain_wr;
            hst_pkg::CSR_GRID_WIDTH:  width_ff  <= width_wr;
            hst_pkg::CSR_GRID_HEIGHT: height_ff <= height_wr;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Flow control: the whole pipeline moves together when the output
   // queue has room for the two results a cell may produce.
   // ---------------------------------------------------------------
   logic [QB:0] count_ff;
   logic        advance;
   logic        accept;

   assign advance   = (count_ff <= (QB+1)'(hst_pkg::OUTQ_DEPTH - 2));
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // ---------------------------------------------------------------
   // Stage 0: position counters
   // ---------------------------------------------------------------
   logic [RB-1:0] row_ff, row_in;
   logic [CB-1:0] col_ff, col_in;
   logic [HB-1:0] r_a, r_n;
   logic [WB-1:0] c_a, c_n;
   hst_pkg::cell_ctl_type ctl0;

   always_comb begin
      r_a = HB'(row_ff);
      c_a = WB'(col_ff);
      if (req_sweep_start) begin
         r_a = '0;
         c_a = '0;
      end
      // shrunk geometry: wrap into the next row / sweep
      if (c_a >= width_ff) begin
         c_a = '0;
         r_a = r_a + 1'b1;
      end
      if (r_a >= height_ff) r_a = '0;

      c_n = c_a + 1'b1;
      r_n = r_a;
      if (c_n >= width_ff) begin
         c_n = '0;
         r_n = r_a + 1'b1;
         if (r_n >= height_ff) r_n = '0;
      end
      row_in = r_n[RB-1:0];
      col_in = c_n[CB-1:0];

      ctl0.do_upd   = (r_a != '0);
      ctl0.interior = (r_a > HB'(1)) && (c_a != '0) && ((c_a + 1'b1) < width_ff);
      ctl0.emit_cur = (r_a == height_ff - 1'b1);
      ctl0.last     = (c_a == width_ff - 1'b1);
      ctl0.row      = r_a[RB-1:0];
      ctl0.col      = c_a[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------------------------------------------------------
   // Row memories. pend_mem holds old values of the latest row and is
   // read (old value) and rewritten at the same column on accept.
   // upd_mem holds updated values of the row above the cell being
   // finished; it is written from stage 3.
   // ---------------------------------------------------------------
   logic signed [DB-1:0] pend_mem [hst_pkg::MAX_WIDTH];
   logic signed [DB-1:0] upd_mem  [hst_pkg::MAX_WIDTH];

   logic signed [DB-1:0] pend_c_ff, pend_e_ff, upd_n_ff, fwd_ff;
   logic                 fwd_hit_ff;
   logic [CB-1:0]        east_addr;

   // stage 3 signals used for write-back
   hst_pkg::cell_ctl_type ctl3_ff;
   logic                  s3_valid_ff;
   logic signed [DB-1:0]  nv;
   logic                  upd_we;

   assign east_addr = ctl0.col + 1'b1;
   assign upd_we    = advance && s3_valid_ff && ctl3_ff.do_upd;

   always_ff @(posedge clock) begin
      if (accept) pend_mem[ctl0.col] <= req_temp_in;
      if (advance) begin
         pend_c_ff <= pend_mem[ctl0.col];
         pend_e_ff <= pend_mem[east_addr];
         upd_n_ff  <= upd_mem[ctl0.col];
         fwd_ff    <= nv;
      end
      if (upd_we) upd_mem[ctl3_ff.col] <= nv;
   end

   // north neighbor written in the same clock as it is read: forward it
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (advance) begin
         fwd_hit_ff <= upd_we && (ctl3_ff.col == ctl0.col);
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: neighbor sum without the west term
   // ---------------------------------------------------------------
   logic                  s1_valid_ff;
   hst_pkg::cell_ctl_type ctl1_ff;
   logic signed [DB-1:0]  x1_ff;
   logic signed [DB-1:0]  north;
   logic signed [PB-1:0]  part;

   always_comb begin
      north = fwd_hit_ff ? fwd_ff : upd_n_ff;
      part  = PB'(north) + PB'(x1_ff) + PB'(pend_e_ff) - (PB'(pend_c_ff) <<< 2);
   end

   // ---------------------------------------------------------------
   // Stage 2: gain multiply of the partial sum
   // ---------------------------------------------------------------
   logic                  s2_valid_ff;
   hst_pkg::cell_ctl_type ctl2_ff;
   logic signed [DB-1:0]  x2_ff, old2_ff;
   logic signed [PB-1:0]  part_ff;
   logic signed [MB-1:0]  prod;
   logic signed [GB:0]    gain_s;

   assign gain_s = $signed({1'b0, gain_ff});
   assign prod   = MB'(part_ff) * MB'(gain_s);

   // ---------------------------------------------------------------
   // Stage 3: west term, rounding, saturation
   // ---------------------------------------------------------------
   logic signed [DB-1:0]  x3_ff, old3_ff;
   logic signed [MB-1:0]  prod_ff;
   logic signed [DB-1:0]  west_ff;
   logic signed [WKB-1:0] west_k;
   logic signed [SB-1:0]  total;
   logic signed [SB-1:0]  delta;
   logic signed [NB-1:0]  nv_wide;

   always_comb begin
      west_k  = WKB'(west_ff) * WKB'(gain_s);
      total   = SB'(prod_ff) + SB'(west_k) + SB'(32768);
      delta   = total >>> 16;
      nv_wide = NB'(old3_ff) + NB'(delta);
      if (!ctl3_ff.interior) begin
         nv = old3_ff;
      end else if (nv_wide[NB-1:DB-1] == '0 || nv_wide[NB-1:DB-1] == '1) begin
         nv = nv_wide[DB-1:0];
      end else if (nv_wide[NB-1]) begin
         nv = {1'b1, {(DB-1){1'b0}}};
      end else begin
         nv = {1'b0, {(DB-1){1'b1}}};
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         west_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff && ctl3_ff.do_upd) west_ff <= nv;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff <= ctl0;
         x1_ff   <= req_temp_in;
         ctl2_ff <= ctl1_ff;
         x2_ff   <= x1_ff;
         old2_ff <= pend_c_ff;
         part_ff <= part;
         ctl3_ff <= ctl2_ff;
         x3_ff   <= x2_ff;
         old3_ff <= old2_ff;
         prod_ff <= prod;
      end
   end

   // ---------------------------------------------------------------
   // Output queue: up to two pushes per clock, one pop
   // ---------------------------------------------------------------
   hst_pkg::result_type outq [hst_pkg::OUTQ_DEPTH];
   logic [QB-1:0]       wr_ptr_ff, rd_ptr_ff, wr_ptr1;
   logic [QB:0]         count_in;
   hst_pkg::result_type res_upd, res_cur, push0_data;
   logic                push0, push1, pop;
   hst_pkg::result_type head;

   always_comb begin
      res_upd.temp = nv;
      res_upd.row  = ctl3_ff.row - 1'b1;
      res_upd.col  = ctl3_ff.col;
      res_upd.last = 1'b0;
      res_cur.temp = x3_ff;
      res_cur.row  = ctl3_ff.row;
      res_cur.col  = ctl3_ff.col;
      res_cur.last = ctl3_ff.last;

      push0      = advance && s3_valid_ff && (ctl3_ff.do_upd || ctl3_ff.emit_cur);
      push1      = advance && s3_valid_ff && ctl3_ff.do_upd && ctl3_ff.emit_cur;
      push0_data = ctl3_ff.do_upd ? res_upd : res_cur;
      wr_ptr1    = wr_ptr_ff + 1'b1;
      pop        = rsp_valid && !rsp_stall;
      count_in   = count_ff + (QB+1)'(push0) + (QB+1)'(push1) - (QB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0) outq[wr_ptr_ff] <= push0_data;
      if (push1) outq[wr_ptr1]   <= res_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QB'(push0) + QB'(push1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   assign head           = outq[rd_ptr_ff];
   assign rsp_valid      = (count_ff != '0);
   assign rsp_temp_out   = head.temp;
   assign rsp_out_row    = head.row;
   assign rsp_out_col    = head.col;
   assign rsp_sweep_last = head.last;

endmodule

// ===== test/hst_sweep_checker.sv =====
// Result checker for heat_stencil_inplace_sweep_core: follows register writes,
// predicts every reported cell of the sweep and compares the result stream in order.
// Depends on hst_pkg for widths, limits, register indexes and the result type.
module hst_sweep_checker
   import hst_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [DATA_BITS-1:0]   req_temp_in,
   input  logic                          req_sweep_start,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [DATA_BITS-1:0]   rsp_temp_out,
   input  logic [ROW_BITS-1:0]           rsp_out_row,
   input  logic [COL_BITS-1:0]           rsp_out_col,
   input  logic                          rsp_sweep_last,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint TEMP_HI      = (longint'(1) <<< (DATA_BITS - 1)) - 1;
   localparam longint TEMP_LO      = -TEMP_HI - 1;
   localparam int     REPORT_LIMIT = 10;

   logic [GAIN_BITS-1:0]        gain_q;
   logic [WIDTH_BITS-1:0]       width_q;
   logic [HEIGHT_BITS-1:0]      height_q;
   logic signed [DATA_BITS-1:0] old_row [MAX_WIDTH];   // old values of the latest row
   logic signed [DATA_BITS-1:0] new_row [MAX_WIDTH];   // updated values, row above
   logic signed [DATA_BITS-1:0] west_temp;
   int                          row_at;
   int                          col_at;
   int                          errors;
   result_type                  expected_cells [$];

   // old + k*(N + S + W + E - 4*old), product rounded half up to Q.16, saturated
   function automatic logic signed [DATA_BITS-1:0] relax_cell(
      input longint center, input longint north, input longint south,
      input longint west, input longint east, input longint gain);
      longint lap;
      longint sum;
      lap = north + south + west + east - 4 * center;
      sum = center + ((lap * gain + 32768) >>> 16);
      if (sum > TEMP_HI) begin
         sum = TEMP_HI;
      end else if (sum < TEMP_LO) begin
         sum = TEMP_LO;
      end
      return DATA_BITS'(sum);
   endfunction

   task automatic advance_sweep(input logic signed [DATA_BITS-1:0] temp, input logic start);
      int                          w;
      int                          h;
      int                          r;
      int                          c;
      longint                      k;
      logic signed [DATA_BITS-1:0] done;
      result_type                  exp_item;
      w = int'(width_q);
      if (w < int'(WIDTH_MIN)) w = int'(WIDTH_MIN);
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = int'(height_q);
      if (h < int'(HEIGHT_MIN)) h = int'(HEIGHT_MIN);
      if (h > int'(HEIGHT_MAX)) h = int'(HEIGHT_MAX);
      k = (gain_q > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain_q);
      r = row_at;
      c = col_at;
      if (start) begin
         r = 0;
         c = 0;
      end
      // geometry shrunk under the counters
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (r >= h) r = 0;
      // finish the cell above
      if (r > 0) begin
         done = old_row[c];
         if (r > 1 && c != 0 && c + 1 < w)
            done = relax_cell(old_row[c], new_row[c], temp, west_temp, old_row[c + 1], k);
         exp_item.temp = done;
         exp_item.row  = ROW_BITS'(r - 1);
         exp_item.col  = COL_BITS'(c);
         exp_item.last = 1'b0;
         expected_cells.push_back(exp_item);
         new_row[c] = done;
         west_temp  = done;
      end
      old_row[c] = temp;
      // last row is reported as it arrives
      if (r == h - 1) begin
         exp_item.temp = temp;
         exp_item.row  = ROW_BITS'(r);
         exp_item.col  = COL_BITS'(c);
         exp_item.last = (c == w - 1);
         expected_cells.push_back(exp_item);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_at = r;
      col_at = c;
   endtask

   task automatic check_result();
      result_type want;
      if (expected_cells.size() == 0) begin
         if (errors < REPORT_LIMIT)
            $display("%t: unexpected result temp %0d row %0d col %0d last %0b", $realtime,
                     rsp_temp_out, rsp_out_row, rsp_out_col, rsp_sweep_last);
         errors++;
      end else begin
         want = expected_cells.pop_front();
         if (want.temp !== rsp_temp_out || want.row !== rsp_out_row ||
             want.col !== rsp_out_col || want.last !== rsp_sweep_last) begin
            if (errors < REPORT_LIMIT)
               $display("%t: cell mismatch: expected temp %0d row %0d col %0d last %0b, %s",
                        $realtime, want.temp, want.row, want.col, want.last,
                        $sformatf("got temp %0d row %0d col %0d last %0b",
                                  rsp_temp_out, rsp_out_row, rsp_out_col, rsp_sweep_last));
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_q   = GAIN_RESET;
         width_q  = WIDTH_RESET;
         height_q = HEIGHT_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            old_row[i] = '0;
            new_row[i] = '0;
         end
         west_temp = '0;
         row_at    = 0;
         col_at    = 0;
         expected_cells.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_GAIN:   gain_q   = csr_wdata[GAIN_BITS-1:0];
               CSR_GRID_WIDTH:  width_q  = csr_wdata[WIDTH_BITS-1:0];
               CSR_GRID_HEIGHT: height_q = csr_wdata[HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) advance_sweep(req_temp_in, req_sweep_start);
      end
      fail_count  <= errors;
      outstanding <= expected_cells.size();
   end

endmodule

// ===== test/tb_heat_stencil_inplace_sweep_core.sv =====
// Testbench top for heat_stencil_inplace_sweep_core: clock, reset, request and
// register stimulus, result-side stall pattern and the final verdict.
// Depends on hst_pkg, the core RTL and hst_sweep_checker.
module tb_heat_stencil_inplace_sweep_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hst_pkg::*;

   // register index with no register behind it; writes must be ignored
   localparam logic [CSR_INDEX_BITS-1:0]  CSR_SPARE = 2'd3;
   localparam logic signed [DATA_BITS-1:0] TEMP_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic signed [DATA_BITS-1:0] TEMP_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
   localparam int RANDOM_CELLS  = 200;
   localparam int WIDE_CELLS    = 520;   // full 512-wide row 0 plus a few cells of row 1
   localparam int SETTLE_CYCLES = 16;    // pipeline is four deep; margin for row-0 cells

   typedef enum {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_BEAT} stall_mode_type;

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic signed [DATA_BITS-1:0] req_temp_in     = '0;
   logic                        req_sweep_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b0;
   logic signed [DATA_BITS-1:0] rsp_temp_out;
   logic [ROW_BITS-1:0]         rsp_out_row;
   logic [COL_BITS-1:0]         rsp_out_col;
   logic                        rsp_sweep_last;
   logic                        csr_valid       = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index       = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata       = '0;
   int                          fail_count;
   int                          outstanding;

   int             burst_left = 0;      // requests left in the current sender burst
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             run_left   = 0;

   heat_stencil_inplace_sweep_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temp_in     (req_temp_in),
      .req_sweep_start (req_sweep_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temp_out    (rsp_temp_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_sweep_last  (rsp_sweep_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   hst_sweep_checker sweep_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_temp_in     (req_temp_in),
      .req_sweep_start (req_sweep_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temp_out    (rsp_temp_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_sweep_last  (rsp_sweep_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result-side back-pressure. The mode is redrawn when its countdown runs out:
   // no stall at all, coin flips, long on/off runs, or a steady 2-of-3 beat
   // that keeps the last-row double results backed up.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_COIN: rsp_stall <= 1'($urandom_range(0, 1));
         STALL_RUNS: begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 12);
               rsp_stall <= !rsp_stall;
            end else begin
               run_left--;
            end
         end
         default: rsp_stall <= (mode_left % 3 != 0);
      endcase
   end

   // Mostly smooth temperatures around a per-phase level, with full-range
   // noise and the range extremes mixed in.
   function automatic logic signed [DATA_BITS-1:0] pick_temp(
      input logic signed [DATA_BITS-1:0] level);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0:       return TEMP_MAX;
               1:       return TEMP_MIN;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: return level + $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
      endcase
   endfunction

   // One request. Valid stays high across back-to-back requests within a burst;
   // a burst ends with a random gap (possibly none) with valid low.
   task automatic send_cell(input logic signed [DATA_BITS-1:0] temp, input logic start);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid       <= 1'b1;
      req_temp_in     <= temp;
      req_sweep_start <= start;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Stop sending, wait for every predicted result, then let the pipeline
   // run dry (cells of row 0 produce nothing but still write the row memory).
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high so that writes can follow back to back
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_grid(input logic [GAIN_BITS-1:0] gain,
                               input logic [WIDTH_BITS-1:0] width,
                               input logic [HEIGHT_BITS-1:0] height,
                               input logic poke_spare);
      settle();
      if (poke_spare) write_register(CSR_SPARE, CSR_DATA_BITS'($urandom));
      write_register(CSR_STEP_GAIN, CSR_DATA_BITS'(gain));
      write_register(CSR_GRID_WIDTH, CSR_DATA_BITS'(width));
      write_register(CSR_GRID_HEIGHT, CSR_DATA_BITS'(height));
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic signed [DATA_BITS-1:0] corner [9];
      logic signed [DATA_BITS-1:0] level;
      logic [GAIN_BITS-1:0]        gain_pick;
      logic [WIDTH_BITS-1:0]       width_pick;
      logic [HEIGHT_BITS-1:0]      height_pick;
      int                          w_eff;
      int                          h_eff;
      int                          cur_width;
      int                          n_cells;
      int                          random_sent;
      logic                        restart;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 3x3 grid at the gain ceiling, spare index poked first. One interior
      // cell; the border carries both ends of the temperature range.
      program_grid(GAIN_MAX, WIDTH_MIN, HEIGHT_MIN, 1'b1);
      corner = '{TEMP_MAX, TEMP_MIN, 32'sd0, -32'sd1, TEMP_MIN, TEMP_MAX,
                 32'sd1, TEMP_MAX, TEMP_MIN};
      foreach (corner[i]) send_cell(corner[i], i == 0);

      // Gain above 16384 must act as 16384. No sweep_start: the counters
      // wrapped after the final cell, so this is row 0 of a fresh sweep.
      program_grid(15'h7FFF, WIDTH_MIN, HEIGHT_MIN, 1'b0);
      send_cell(32'sh0001_0000, 1'b0);
      send_cell(-32'sh0001_0000, 1'b0);
      send_cell(TEMP_MIN, 1'b0);
      send_cell(TEMP_MAX, 1'b0);

      // 5x4 grid, stop at row 1 col 3; then shrink to 3x3 under the counters:
      // the next cell becomes column 0 of row 2, which is the last row.
      program_grid(15'd1, 10'd5, 13'd4, 1'b0);
      for (int i = 0; i < 8; i++) send_cell(pick_temp(32'sd0), i == 0);
      program_grid(15'd8192, WIDTH_MIN, HEIGHT_MIN, 1'b0);
      for (int i = 0; i < 3; i++) send_cell(pick_temp(32'sd0), 1'b0);

      // Widest row (register saturates to 512), partial second row; the random
      // phases that follow shrink the width under the counters.
      program_grid(15'($urandom_range(0, 16384)), 10'h3FF, HEIGHT_MIN, 1'b0);
      level = $signed($urandom) >>> 8;
      for (int i = 0; i < WIDE_CELLS; i++) send_cell(pick_temp(level), i == 0);
      cur_width = MAX_WIDTH;

      // Random phases: new registers each time, then whole sweeps of smooth data
      // with the odd restart in mid-sweep. A phase that widens the grid restarts
      // the sweep on its first cell so no row entry is read before it is written.
      random_sent = 0;
      while (random_sent < RANDOM_CELLS) begin
         case ($urandom_range(0, 7))
            0:       gain_pick = '0;
            1:       gain_pick = GAIN_MAX;
            2:       gain_pick = 15'($urandom_range(16385, 32767));
            default: gain_pick = 15'($urandom_range(1, 16383));
         endcase
         case ($urandom_range(0, 9))
            0:       width_pick = 10'($urandom_range(0, 2));
            1:       width_pick = 10'($urandom_range(13, 40));
            2:       width_pick = WIDTH_MIN;
            default: width_pick = 10'($urandom_range(4, 12));
         endcase
         case ($urandom_range(0, 11))
            0:       height_pick = 13'($urandom_range(0, 2));
            1:       height_pick = 13'h1FFF;
            2:       height_pick = HEIGHT_MAX;
            3:       height_pick = 13'($urandom_range(9, 8191));
            default: height_pick = 13'($urandom_range(3, 8));
         endcase
         program_grid(gain_pick, width_pick, height_pick, $urandom_range(0, 7) == 0);

         w_eff = (width_pick < WIDTH_MIN) ? int'(WIDTH_MIN) : int'(width_pick);
         if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
         h_eff = (height_pick < HEIGHT_MIN) ? int'(HEIGHT_MIN) : int'(height_pick);
         restart = (w_eff > cur_width);
         cur_width = w_eff;

         n_cells = w_eff * ((h_eff < 8) ? h_eff : 8) * int'($urandom_range(1, 2))
                   + int'($urandom_range(0, w_eff));
         level = $signed($urandom) >>> $urandom_range(2, 12);
         for (int i = 0; i < n_cells; i++) begin
            if (i == 0)
               send_cell(pick_temp(level), restart || $urandom_range(0, 3) == 0);
            else
               send_cell(pick_temp(level), $urandom_range(0, 63) == 0);
         end
         random_sent += n_cells;
      end

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("heat_stencil_inplace_sweep_core test passed");
      end else begin
         $display("heat_stencil_inplace_sweep_core test failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("heat_stencil_inplace_sweep_core test failed");
      $finish;
   end

endmodule
